### hw/rtl/ps2sa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2sa_pkg
// Types, scancode constants and key maps shared by the scancode decoder.
// ----------------------------------------------------------------------------
package ps2sa_pkg;

  localparam int PS2SA_FIFO_DEPTH = 64;
  localparam int TABLE_SIZE       = 58;
  localparam int CFG_IDX_W        = 3;

  typedef enum logic [1:0] {
    KIND_SCAN = 2'd0,
    KIND_READ = 2'd1,
    KIND_FG   = 2'd2,
    KIND_WAIT = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UP     = 3'd0,
    REG_DOWN   = 3'd1,
    REG_LEFT   = 3'd2,
    REG_RIGHT  = 3'd3,
    REG_DELETE = 3'd4,
    REG_TAB    = 3'd5,
    REG_FKEY   = 3'd6
  } reg_idx_t;

  localparam logic [7:0] SC_PREFIX      = 8'hE0;
  localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
  localparam logic [7:0] SC_CTRL_BRK    = 8'h9D;
  localparam logic [7:0] SC_ALT_BRK     = 8'hB8;
  localparam logic [7:0] SC_LSHIFT      = 8'h2A;
  localparam logic [7:0] SC_RSHIFT      = 8'h36;
  localparam logic [7:0] SC_CTRL        = 8'h1D;
  localparam logic [7:0] SC_ALT         = 8'h38;
  localparam logic [7:0] SC_CAPS        = 8'h3A;
  localparam logic [7:0] SC_KEY_C       = 8'h2E;
  localparam logic [7:0] SC_F1          = 8'h3B;
  localparam logic [7:0] SC_F10         = 8'h44;
  localparam logic [7:0] SC_TAB         = 8'h0F;
  localparam logic [7:0] SC_BACKSPACE   = 8'h0E;
  localparam logic [7:0] SC_ENTER       = 8'h1C;
  localparam logic [7:0] SC_ESC         = 8'h01;
  localparam logic [7:0] SC_EXT_UP      = 8'h48;
  localparam logic [7:0] SC_EXT_DOWN    = 8'h50;
  localparam logic [7:0] SC_EXT_LEFT    = 8'h4B;
  localparam logic [7:0] SC_EXT_RIGHT   = 8'h4D;
  localparam logic [7:0] SC_EXT_DELETE  = 8'h53;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_ESCAPE    = 8'h1B;

  typedef struct packed {
    logic [7:0] up;
    logic [7:0] down;
    logic [7:0] left;
    logic [7:0] right;
    logic [7:0] del;
    logic [7:0] tab;
    logic [7:0] fkey_base;
  } codes_t;

  localparam codes_t CODES_RESET = '{
    up: 8'd128, down: 8'd129, left: 8'd130, right: 8'd131,
    del: 8'd132, tab: 8'd9, fkey_base: 8'd133
  };

  typedef struct packed {
    logic prefix;
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
  } flags_t;

  typedef struct packed {
    flags_t     flags_next;
    logic       push;
    logic [7:0] push_code;
    logic       wake;
    logic       ctrl_c;
  } dec_t;

  localparam logic [7:0] PLAIN_MAP [TABLE_SIZE] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h00, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h00, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  localparam logic [7:0] SHIFTED_MAP [TABLE_SIZE] = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h00, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

endpackage

### hw/rtl/ps2sa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2sa_if
// Request and result channels of the scancode decoder.
// ----------------------------------------------------------------------------
interface ps2sa_in_if;
  logic              valid;
  logic              ready;
  logic        [1:0] kind;
  logic        [7:0] scancode;
  logic signed [8:0] task_id;

  modport source (output valid, kind, scancode, task_id, input ready);
  modport sink (input valid, kind, scancode, task_id, output ready);
endinterface

interface ps2sa_out_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] char_out;
  logic       has_char;
  logic       ctrl_held;
  logic       alt_held;
  logic       caps_active;
  logic       wake_valid;
  logic [7:0] wake_task;
  logic       interrupt_valid;
  logic [7:0] interrupt_task;

  modport source (
    output valid, char_valid, char_out, has_char, ctrl_held, alt_held, caps_active,
           wake_valid, wake_task, interrupt_valid, interrupt_task,
    input  ready
  );
  modport sink (
    input  valid, char_valid, char_out, has_char, ctrl_held, alt_held, caps_active,
           wake_valid, wake_task, interrupt_valid, interrupt_task,
    output ready
  );
endinterface

### hw/rtl/ps2sa_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2sa_decoder
// Set-1 scancode decode: modifier tracking, key maps and character forming.
// ----------------------------------------------------------------------------
module ps2sa_decoder
  import ps2sa_pkg::*;
(
  input  logic [7:0] scancode,
  input  flags_t     flags,
  input  codes_t     codes,
  output dec_t       dec
);

  logic [7:0] c_map;
  logic [7:0] c_case;
  logic [7:0] c_ctrl;
  logic [5:0] tidx;

  always_comb begin
    tidx   = scancode[5:0];
    c_map  = 8'h00;
    if (scancode < 8'(TABLE_SIZE)) begin
      c_map = flags.shift ? SHIFTED_MAP[tidx] : PLAIN_MAP[tidx];
    end
    c_case = (flags.caps && is_letter(c_map)) ? (c_map ^ 8'h20) : c_map;
    c_ctrl = (flags.ctrl && is_letter(c_case)) ? {3'b000, c_case[4:0]} : c_case;
  end

  always_comb begin
    dec            = '0;
    dec.flags_next = flags;
    if (scancode == SC_PREFIX) begin
      dec.flags_next.prefix = 1'b1;
    end else if (scancode == SC_LSHIFT_BRK || scancode == SC_RSHIFT_BRK) begin
      dec.flags_next.shift  = 1'b0;
      dec.flags_next.prefix = 1'b0;
    end else if (scancode == SC_CTRL_BRK) begin
      dec.flags_next.ctrl   = 1'b0;
      dec.flags_next.prefix = 1'b0;
    end else if (scancode == SC_ALT_BRK) begin
      dec.flags_next.alt    = 1'b0;
      dec.flags_next.prefix = 1'b0;
    end else if (scancode[7]) begin
      dec.flags_next.prefix = 1'b0;
    end else if (scancode == SC_LSHIFT || scancode == SC_RSHIFT) begin
      dec.flags_next.shift = 1'b1;
    end else if (scancode == SC_CTRL) begin
      dec.flags_next.ctrl = 1'b1;
    end else if (scancode == SC_ALT) begin
      dec.flags_next.alt = 1'b1;
    end else if (scancode == SC_CAPS) begin
      dec.flags_next.caps = ~flags.caps;
    end else if (flags.prefix) begin
      dec.flags_next.prefix = 1'b0;
      dec.push = 1'b1;
      case (scancode)
        SC_EXT_UP:     dec.push_code = codes.up;
        SC_EXT_DOWN:   dec.push_code = codes.down;
        SC_EXT_LEFT:   dec.push_code = codes.left;
        SC_EXT_RIGHT:  dec.push_code = codes.right;
        SC_EXT_DELETE: dec.push_code = codes.del;
        default:       dec.push      = 1'b0;
      endcase
    end else if (scancode == SC_TAB) begin
      dec.push      = 1'b1;
      dec.push_code = codes.tab;
      dec.wake      = 1'b1;
    end else if (scancode >= SC_F1 && scancode <= SC_F10) begin
      dec.push      = 1'b1;
      dec.push_code = codes.fkey_base + (scancode - SC_F1);
      dec.wake      = 1'b1;
    end else if (scancode == SC_BACKSPACE) begin
      dec.push      = 1'b1;
      dec.push_code = CH_BACKSPACE;
      dec.wake      = 1'b1;
    end else if (scancode == SC_ENTER) begin
      dec.push      = 1'b1;
      dec.push_code = CH_NEWLINE;
      dec.wake      = 1'b1;
    end else if (scancode == SC_ESC) begin
      dec.push      = 1'b1;
      dec.push_code = CH_ESCAPE;
      dec.wake      = 1'b1;
    end else if (flags.ctrl && scancode == SC_KEY_C) begin
      dec.ctrl_c = 1'b1;
    end else begin
      // keys past the table still release the waiter
      dec.push      = (c_ctrl != 8'h00);
      dec.push_code = c_ctrl;
      dec.wake      = 1'b1;
    end
  end

endmodule

### hw/rtl/ps2_scancode_to_ascii_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_scancode_to_ascii_fifo
// PS/2 set-1 keyboard decoder with a character ring buffer and task wakeups.
// ----------------------------------------------------------------------------
// One request per clock is accepted on scan while the result channel does not
// stall; each gives exactly one result, registered in stage 1 (decode, buffer
// update, character memory read) and then in the result register. The buffer
// is a single-port-write, single-port-read memory of FIFO_DEPTH bytes holding
// up to FIFO_DEPTH-1 characters; a character that arrives while it is full is
// dropped. The code registers may be written on cfg_write at any time the
// block is idle and take effect on the next request.
module ps2_scancode_to_ascii_fifo
  import ps2sa_pkg::*;
#(
  parameter int FIFO_DEPTH = PS2SA_FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  ps2sa_in_if.sink             scan,
  ps2sa_out_if.source          result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);

  codes_t        codes;
  flags_t        flags;
  dec_t          dec;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] wr_idx;
  logic [AW-1:0] rd_idx_next;
  logic [AW-1:0] wr_idx_next;
  logic [AW-1:0] wr_idx_inc;
  logic [AW-1:0] rd_idx_inc;
  logic          fg_valid;
  logic [7:0]    fg_task;
  logic          wait_valid;
  logic [7:0]    wait_task;

  logic [7:0]    store [FIFO_DEPTH];
  logic [7:0]    rdata;

  logic          accept;
  logic          is_scan;
  logic          is_read;
  logic          do_push;
  logic          do_pop;
  logic          s1_move;

  logic          s1_valid;
  logic          s1_read;
  logic          s1_has_char;
  flags_t        s1_flags;
  logic          s1_wake;
  logic [7:0]    s1_wake_task;
  logic          s1_irq;
  logic [7:0]    s1_irq_task;

  ps2sa_decoder u_decoder (
    .scancode (scan.scancode),
    .flags    (flags),
    .codes    (codes),
    .dec      (dec)
  );

  assign s1_move    = s1_valid && (!result.valid || result.ready);
  assign scan.ready = !s1_valid || s1_move;
  assign accept     = scan.valid && scan.ready;
  assign is_scan    = (scan.kind == KIND_SCAN);
  assign is_read    = (scan.kind == KIND_READ);

  assign wr_idx_inc = (wr_idx == LAST_IDX) ? '0 : wr_idx + 1'b1;
  assign rd_idx_inc = (rd_idx == LAST_IDX) ? '0 : rd_idx + 1'b1;
  assign do_push    = accept && is_scan && dec.push && (wr_idx_inc != rd_idx);
  assign do_pop     = accept && is_read && (rd_idx != wr_idx);
  assign wr_idx_next = do_push ? wr_idx_inc : wr_idx;
  assign rd_idx_next = do_pop ? rd_idx_inc : rd_idx;

  // code registers
  always_ff @(posedge clk) begin
    if (rst) begin
      codes <= CODES_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_UP:     codes.up        <= cfg_data;
        REG_DOWN:   codes.down      <= cfg_data;
        REG_LEFT:   codes.left      <= cfg_data;
        REG_RIGHT:  codes.right     <= cfg_data;
        REG_DELETE: codes.del       <= cfg_data;
        REG_TAB:    codes.tab       <= cfg_data;
        REG_FKEY:   codes.fkey_base <= cfg_data;
        default:    codes           <= codes;
      endcase
    end
  end

  // character memory
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_idx] <= dec.push_code;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_read) begin
      rdata <= store[rd_idx];
    end
  end

  // decoder state and task slots
  always_ff @(posedge clk) begin
    if (rst) begin
      flags      <= '0;
      rd_idx     <= '0;
      wr_idx     <= '0;
      fg_valid   <= 1'b0;
      fg_task    <= '0;
      wait_valid <= 1'b0;
      wait_task  <= '0;
    end else if (accept) begin
      rd_idx <= rd_idx_next;
      wr_idx <= wr_idx_next;
      case (kind_t'(scan.kind))
        KIND_SCAN: begin
          flags <= dec.flags_next;
          if (dec.wake) begin
            wait_valid <= 1'b0;
          end
          if (dec.ctrl_c) begin
            fg_valid <= 1'b0;
          end
        end
        KIND_FG: begin
          fg_valid <= ~scan.task_id[8];
          fg_task  <= scan.task_id[7:0];
        end
        KIND_WAIT: begin
          wait_valid <= ~scan.task_id[8];
          wait_task  <= scan.task_id[7:0];
        end
        default: begin
          fg_valid <= fg_valid;
        end
      endcase
    end
  end

  // stage 1: waits for the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_read      <= do_pop;
      s1_has_char  <= (rd_idx_next != wr_idx_next);
      s1_flags     <= is_scan ? dec.flags_next : flags;
      s1_wake      <= is_scan && dec.wake && wait_valid;
      s1_wake_task <= (is_scan && dec.wake && wait_valid) ? wait_task : 8'h00;
      s1_irq       <= is_scan && dec.ctrl_c && fg_valid;
      s1_irq_task  <= (is_scan && dec.ctrl_c && fg_valid) ? fg_task : 8'h00;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_move) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result.char_valid      <= s1_read;
      result.char_out        <= s1_read ? rdata : 8'h00;
      result.has_char        <= s1_has_char;
      result.ctrl_held       <= s1_flags.ctrl;
      result.alt_held        <= s1_flags.alt;
      result.caps_active     <= s1_flags.caps;
      result.wake_valid      <= s1_wake;
      result.wake_task       <= s1_wake_task;
      result.interrupt_valid <= s1_irq;
      result.interrupt_task  <= s1_irq_task;
    end
  end

endmodule
